@@ hdl/fvn_pkg.sv @@
package fvn_pkg;

   localparam int ACC_W      = 40;
   localparam int OCT_W      = 5;
   localparam int AMP_W      = 17;
   localparam int WGT_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int OUT_W      = 35;

   localparam logic [CSR_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERSISTENCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_MODE  = 2'd2;

   localparam logic [3:0]       OCTAVE_COUNT_RST = 4'd8;
   localparam logic [AMP_W-1:0] PERSISTENCE_RST  = 17'd42598;
   localparam logic [AMP_W-1:0] AMP_ONE          = 17'd65536;

   localparam longint PI_Q28  = 64'd843314857;
   localparam longint ONE_Q28 = 64'd268435456;
   localparam longint unsigned TAYLOR_DIV [10] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   localparam logic signed [ACC_W-1:0] OUT_MAX = 40'sd17179869183;
   localparam logic signed [ACC_W-1:0] OUT_MIN = -40'sd17179869184;

   // Word travelling from one octave cell to the next.
   typedef struct packed {
      logic                     valid;
      logic signed [31:0]       bx;
      logic signed [31:0]       by;
      logic signed [ACC_W-1:0]  total;
      logic [AMP_W-1:0]         amp;
   } oct_bus_type;

   typedef struct packed {
      logic [OCT_W-1:0] oct_lim;
      logic [AMP_W-1:0] per;
      logic             cos_mode;
   } oct_cfg_type;

   typedef struct packed {
      oct_bus_type      bus;
      logic [AMP_W-1:0] amp_nx;
      logic [WGT_W-1:0] wx;
      logic [WGT_W-1:0] wy;
   } oct_carry_type;

endpackage

@@ hdl/fvn_hash.sv @@
module fvn_hash import fvn_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        x,
   input  logic [31:0]        y,
   output logic signed [31:0] v
);

   logic [31:0] n0;
   logic [31:0] n_in, n_ff;
   logic [31:0] m_in, m_ff, nb_ff;
   logic [31:0] p_in, p_ff, nc_ff;
   logic [31:0] q;
   logic signed [31:0] v_in, v_ff;

   always_comb begin
      n0   = x + 32'(y * 32'd57);
      n_in = (n0 << 13) ^ n0;
      m_in = 32'(n_ff * n_ff);
      p_in = 32'(m_ff * 32'd15731) + 32'd789221;
      q    = 32'(nc_ff * p_ff) + 32'd1376312589;
      v_in = 32'sd1073741824 - $signed({1'b0, q[30:0]});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff  <= n_in;
         m_ff  <= m_in;
         nb_ff <= n_ff;
         p_ff  <= p_in;
         nc_ff <= nb_ff;
         v_ff  <= v_in;
      end
   end

   assign v = v_ff;

endmodule

@@ hdl/fvn_cell.sv @@
module fvn_cell import fvn_pkg::*; #(
   parameter int OCT_IDX            = 0,
   parameter int COORD_FRAC_BITS    = 16,
   parameter int COSINE_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  oct_cfg_type cfg,
   input  oct_bus_type bus_i,
   output oct_bus_type bus_o
);

   localparam int F       = COORD_FRAC_BITS;
   localparam int D       = COSINE_TABLE_DEPTH;
   localparam int IDX_W   = $clog2(D);
   localparam int FR_DOWN = (F > 16) ? F - 16 : 0;
   localparam int FR_UP   = (F < 16) ? 16 - F : 0;
   localparam int NSTG    = 7;
   localparam logic [63:0] FMASK = (64'd1 << F) - 64'd1;

   function automatic logic [WGT_W-1:0] wtab_entry(input int k);
      longint unsigned kk, x, x2, term;
      longint          sum, c;
      kk   = (2 * k > D) ? longint'(D - k) : longint'(k);
      x    = (PI_Q28 * kk) / D;
      x2   = (x * x) >> 28;
      term = ONE_Q28;
      sum  = ONE_Q28;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 28) / TAYLOR_DIV[n-1];
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      c = (2 * k > D) ? -sum : sum;
      if (c > ONE_Q28) c = ONE_Q28;
      if (c < -ONE_Q28) c = -ONE_Q28;
      return WGT_W'((ONE_Q28 - c + 64'd4096) >>> 13);
   endfunction

   function automatic logic signed [35:0] blend(input logic signed [35:0] a,
                                                input logic signed [35:0] b,
                                                input logic [WGT_W-1:0] w);
      logic signed [54:0] d, p;
      d = 55'(b) - 55'(a);
      p = d * 55'($signed({1'b0, w}));
      return a + 36'(p >>> 16);
   endfunction

   logic [WGT_W-1:0] wtab [D];
   for (genvar k = 0; k < D; k++) begin : g_tab
      assign wtab[k] = wtab_entry(k);
   end

   // Stage A: lattice position, fraction and blend weight for this octave.
   logic [63:0]      ext_x, ext_y, sh_x, sh_y, fr_x, fr_y;
   logic [31:0]      xi, yi;
   logic [15:0]      tx, ty;
   logic [IDX_W-1:0] idx_x, idx_y;
   logic [WGT_W-1:0] wx, wy;
   logic [33:0]      amp_prod;
   logic [AMP_W-1:0] amp_nx;

   always_comb begin
      ext_x    = {{32{bus_i.bx[31]}}, bus_i.bx};
      ext_y    = {{32{bus_i.by[31]}}, bus_i.by};
      sh_x     = ext_x << OCT_IDX;
      sh_y     = ext_y << OCT_IDX;
      xi       = sh_x[F+31:F];
      yi       = sh_y[F+31:F];
      fr_x     = sh_x & FMASK;
      fr_y     = sh_y & FMASK;
      tx       = (F >= 16) ? 16'(fr_x >> FR_DOWN) : 16'(fr_x << FR_UP);
      ty       = (F >= 16) ? 16'(fr_y >> FR_DOWN) : 16'(fr_y << FR_UP);
      idx_x    = IDX_W'((32'(tx) * 32'(D)) >> 16);
      idx_y    = IDX_W'((32'(ty) * 32'(D)) >> 16);
      wx       = cfg.cos_mode ? wtab[idx_x] : {1'b0, tx};
      wy       = cfg.cos_mode ? wtab[idx_y] : {1'b0, ty};
      amp_prod = {17'd0, bus_i.amp} * {17'd0, cfg.per};
      amp_nx   = AMP_W'(amp_prod >> 16);
   end

   // Stages A to D: 4x4 lattice values around the sample, one hash pipe each.
   logic signed [31:0] lat [4][4];
   for (genvar j = 0; j < 4; j++) begin : g_hx
      for (genvar k = 0; k < 4; k++) begin : g_hy
         fvn_hash u_hash (
            .clock (clock),
            .adv   (adv),
            .x     (xi + 32'(j) - 32'd1),
            .y     (yi + 32'(k) - 32'd1),
            .v     (lat[j][k])
         );
      end
   end

   oct_carry_type carry_in [NSTG];
   oct_carry_type carry_ff [NSTG];

   always_comb begin
      carry_in[0] = '{bus: bus_i, amp_nx: amp_nx, wx: wx, wy: wy};
      for (int s = 1; s < NSTG; s++) carry_in[s] = carry_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) carry_ff[s].bus.valid <= 1'b0;
      end else if (adv) begin
         carry_ff <= carry_in;
      end
   end

   // Stage E: 3x3 smoothing of the four corners, kept at sixteen times scale.
   logic signed [35:0] s_in [4];
   logic signed [35:0] s_ff [4];
   for (genvar a = 0; a < 2; a++) begin : g_sa
      for (genvar b = 0; b < 2; b++) begin : g_sb
         assign s_in[a+2*b] = 36'sd4 * 36'(lat[1+a][1+b])
            + 36'sd2 * (36'(lat[a][1+b]) + 36'(lat[2+a][1+b])
                        + 36'(lat[1+a][b]) + 36'(lat[1+a][2+b]))
            + 36'(lat[a][b]) + 36'(lat[2+a][b])
            + 36'(lat[a][2+b]) + 36'(lat[2+a][2+b]);
      end
   end

   // Stages F and G: blend along x, then along y.
   logic signed [35:0] ex_in [2];
   logic signed [35:0] ex_ff [2];
   logic signed [35:0] r_in, r_ff;

   assign ex_in[0] = blend(s_ff[0], s_ff[1], carry_ff[4].wx);
   assign ex_in[1] = blend(s_ff[2], s_ff[3], carry_ff[4].wx);
   assign r_in     = blend(ex_ff[0], ex_ff[1], carry_ff[5].wy);

   // Stage H: scale by the amplitude and, for an octave below the octave count, add into the running sum.
   logic               active;
   logic signed [53:0] term_prod;
   oct_bus_type        bus_in, bus_ff;

   always_comb begin
      active       = 5'(OCT_IDX) < cfg.oct_lim;
      term_prod    = 54'(r_ff) * 54'($signed({1'b0, carry_ff[6].bus.amp}));
      bus_in       = carry_ff[6].bus;
      bus_in.amp   = carry_ff[6].amp_nx;
      if (active) begin
         bus_in.total = carry_ff[6].bus.total + ACC_W'(term_prod >>> 20);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff  <= s_in;
         ex_ff <= ex_in;
         r_ff  <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (adv) begin
         bus_ff <= bus_in;
      end
   end

   assign bus_o = bus_ff;

endmodule

@@ hdl/fractal_value_noise_2d_top.sv @@
// Throughput: one word per cycle while no response word is stalled; each octave cell
// is an eight-stage pipeline and the cells are chained, one per octave, so every
// stage holds a different sample.
// The whole chain advances together and holds while a response word is stalled.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: eight octaves, persistence 42598, linear interpolation.
module fractal_value_noise_2d_top import fvn_pkg::*; #(
   parameter int MAX_OCTAVES        = 8,
   parameter int COORD_FRAC_BITS    = 16,
   parameter int COSINE_TABLE_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_noise_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [3:0]       oct_cnt_ff;
   logic [AMP_W-1:0] persist_ff;
   logic             interp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cnt_ff <= OCTAVE_COUNT_RST;
         persist_ff <= PERSISTENCE_RST;
         interp_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_OCTAVE_COUNT: oct_cnt_ff <= csr_wdata[3:0];
            REG_PERSISTENCE:  persist_ff <= csr_wdata[AMP_W-1:0];
            REG_INTERP_MODE:  interp_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   oct_cfg_type cfg;
   always_comb begin
      cfg.oct_lim  = (5'(oct_cnt_ff) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : 5'(oct_cnt_ff);
      cfg.per      = (persist_ff > AMP_ONE) ? AMP_ONE : persist_ff;
      cfg.cos_mode = interp_ff;
   end

   logic rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic adv;

   // The chain moves whenever the output register is empty or being drained.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   oct_bus_type bus [MAX_OCTAVES+1];
   assign bus[0] = '{valid: req_valid, bx: req_coord_x, by: req_coord_y,
                     total: '0, amp: AMP_ONE};

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      fvn_cell #(
         .OCT_IDX            (i),
         .COORD_FRAC_BITS    (COORD_FRAC_BITS),
         .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .cfg   (cfg),
         .bus_i (bus[i]),
         .bus_o (bus[i+1])
      );
   end

   logic signed [ACC_W-1:0] total, sat;
   always_comb begin
      total = bus[MAX_OCTAVES].total;
      if (total > OUT_MAX) sat = OUT_MAX;
      else if (total < OUT_MIN) sat = OUT_MIN;
      else sat = total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= bus[MAX_OCTAVES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= sat[OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

@@ hdl/fvn_checker.sv @@
module fvn_port_props import fvn_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_noise_value
);

   // A reset leaves no response word behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word present after reset");

   // A held response word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled response word changed");

   // While the output is blocked the input must be blocked too.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response is stalled");

   // With the output empty the block never refuses a word.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

endmodule

bind fractal_value_noise_2d_top fvn_port_props u_fvn_port_props (.*);

@@ bench/fvn_checker.sv @@
`timescale 1ns / 100ps

module fvn_checker import fvn_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic signed [31:0]      req_coord_x,
   input  logic signed [31:0]      req_coord_y,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_noise_value,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      fail_count,
   output int                      pending_count
);

   localparam int OCT_MAX   = 8;
   localparam int TAB_DEPTH = 256;

   logic [3:0]  octaves_q;
   logic [16:0] persist_q;
   logic        cosine_q;
   logic [16:0] cos_weight [TAB_DEPTH];
   logic signed [OUT_W-1:0] expected_noise [$];

   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cos_q28(longint unsigned x);
      longint unsigned x2, term;
      longint sum;
      x2 = (x * x) >> 28;
      term = ONE_Q28;
      sum = ONE_Q28;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      return sum;
   endfunction

   function automatic longint lattice_value(logic [31:0] x, logic [31:0] y);
      logic [31:0] n, nn;
      n = x + y * 32'd57;
      n = (n << 13) ^ n;
      nn = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return 64'sd1073741824 - longint'({32'd0, nn});
   endfunction

   function automatic longint smooth16(logic [31:0] x, logic [31:0] y);
      longint c, s, k;
      c = lattice_value(x, y);
      s = lattice_value(x + 1, y) + lattice_value(x - 1, y)
        + lattice_value(x, y + 1) + lattice_value(x, y - 1);
      k = lattice_value(x + 1, y + 1) + lattice_value(x - 1, y + 1)
        + lattice_value(x + 1, y - 1) + lattice_value(x - 1, y - 1);
      return 4 * c + 2 * s + k;
   endfunction

   function automatic longint mix(longint a, longint b, logic [16:0] w);
      return a + floor_div((b - a) * longint'({47'd0, w}), 16);
   endfunction

   function automatic logic [16:0] blend_weight(logic [15:0] t);
      if (cosine_q) return cos_weight[(32'(t) * TAB_DEPTH) >> 16];
      return {1'b0, t};
   endfunction

   function automatic logic signed [OUT_W-1:0] octave_sum(logic signed [31:0] cx,
                                                          logic signed [31:0] cy);
      longint sx, sy, total, r;
      longint unsigned amp;
      logic [31:0] xi, yi;
      logic [16:0] wx, wy;
      int oct;
      logic [16:0] per;
      oct = octaves_q > OCT_MAX ? OCT_MAX : octaves_q;
      per = persist_q > 17'd65536 ? 17'd65536 : persist_q;
      amp = 65536;
      total = 0;
      for (int i = 0; i < oct; i++) begin
         sx = longint'(cx) <<< i;
         sy = longint'(cy) <<< i;
         xi = sx[47:16];
         yi = sy[47:16];
         wx = blend_weight(sx[15:0]);
         wy = blend_weight(sy[15:0]);
         r = mix(mix(smooth16(xi, yi), smooth16(xi + 1, yi), wx),
                 mix(smooth16(xi, yi + 1), smooth16(xi + 1, yi + 1), wx), wy);
         total += floor_div(r * longint'(amp), 20);
         amp = (amp * per) >> 16;
      end
      if (total > 64'sd17179869183) total = 64'sd17179869183;
      if (total < -64'sd17179869184) total = -64'sd17179869184;
      return total[OUT_W-1:0];
   endfunction

   initial begin
      longint c;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         if (2 * k > TAB_DEPTH) c = -cos_q28((PI_Q28 * (TAB_DEPTH - k)) / TAB_DEPTH);
         else c = cos_q28((PI_Q28 * k) / TAB_DEPTH);
         if (c > ONE_Q28) c = ONE_Q28;
         if (c < -ONE_Q28) c = -ONE_Q28;
         cos_weight[k] = 17'((ONE_Q28 - c + 4096) >>> 13);
      end
   end

   assign pending_count = expected_noise.size();

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (reset) begin
         octaves_q <= OCTAVE_COUNT_RST;
         persist_q <= PERSISTENCE_RST;
         cosine_q <= 1'b0;
         fail_count <= 0;
         expected_noise.delete();
      end else begin
         // Predict with the settings in force before any write on this edge.
         if (req_valid && !req_stall)
            expected_noise = {expected_noise, octave_sum(req_coord_x, req_coord_y)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_noise.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected noise word %h", rsp_noise_value);
            end else begin
               want = expected_noise.pop_front();
               if (want !== rsp_noise_value) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("noise mismatch: expected %h got %h", want, rsp_noise_value);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OCTAVE_COUNT: octaves_q <= csr_wdata[3:0];
               REG_PERSISTENCE: persist_q <= csr_wdata;
               REG_INTERP_MODE: cosine_q <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ bench/tb_fractal_value_noise_2d_top.sv @@
`timescale 1ns / 100ps

module tb_fractal_value_noise_2d_top;
   import fvn_pkg::*;

   localparam int LATENCY = 8 * 8 + 1;
   // Index past the last register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_noise_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count, pending_count;
   bit calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fractal_value_noise_2d_top dut (.*);

   fvn_checker checker_i (.*);

   // Receiver stalls at random, except during the calm stretch.
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 35);

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pipe();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y);
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
         2: return {$urandom_range(8) == 0 ? 16'h8000 : 16'h7fff, 16'($urandom)};
         default: return {16'($urandom_range(40)) - 16'd20, 16'($urandom)};
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_point(rand_coord(), rand_coord());
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_point(32'h0, 32'h0);
      send_point(32'h7fffffff, 32'h80000000);
      send_point(32'h80000000, 32'h7fffffff);
      send_point(32'hffffffff, 32'h0000ffff);
      send_point(32'h00008000, 32'hffff8000);
      send_point(32'h12345678, 32'hedcba987);
      send_point(32'h0001ffff, 32'h00010000);
      req_valid <= 1'b0;
      drain_pipe();
      write_reg(REG_INTERP_MODE, 17'd1);
      write_reg(REG_OCTAVE_COUNT, 17'd15);
      write_reg(REG_PERSISTENCE, 17'h1ffff);
      send_point(32'h7fffffff, 32'h7fffffff);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h00004000, 32'h0000c000);
      req_valid <= 1'b0;
      drain_pipe();
      write_reg(REG_OCTAVE_COUNT, 17'd0);
      send_point(32'h11111111, 32'h22222222);
      req_valid <= 1'b0;
      drain_pipe();
      write_reg(REG_OCTAVE_COUNT, 17'd1);
      write_reg(REG_PERSISTENCE, 17'd0);
      write_reg(REG_INTERP_MODE, 17'h1fffe);
      send_point(32'h7fffffff, 32'hffffffff);
      send_point(32'h0000ffff, 32'h00000001);
      req_valid <= 1'b0;
      drain_pipe();
      write_reg(REG_UNUSED, 17'h1ffff);
      write_reg(REG_OCTAVE_COUNT, 17'd8);
      write_reg(REG_PERSISTENCE, 17'd42598);
      random_phase(170);
      drain_pipe();
      calm = 1'b1;
      write_reg(REG_INTERP_MODE, 17'd1);
      write_reg(REG_PERSISTENCE, 17'd65536);
      random_phase(160);
      calm = 1'b0;
      drain_pipe();
      write_reg(REG_OCTAVE_COUNT, 17'd3);
      write_reg(REG_PERSISTENCE, 17'($urandom));
      random_phase(160);
      drain_pipe();
      write_reg(REG_OCTAVE_COUNT, 17'd9);
      write_reg(REG_INTERP_MODE, 17'd0);
      random_phase(150);
      drain_pipe();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/fvn_pkg.sv
hdl/fvn_hash.sv
hdl/fvn_cell.sv
hdl/fractal_value_noise_2d_top.sv
hdl/fvn_checker.sv
bench/fvn_checker.sv
bench/tb_fractal_value_noise_2d_top.sv
